// ----- hdl/sdil_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdil_pkg: shared types and codes of the sorted descending insert list
// Entry layout, opcodes and the fixed field widths used by the cells and top.
// ----------------------------------------------------------------------------
package sdil_pkg;

  localparam int KEY_W    = 32;
  localparam int HANDLE_W = 16;
  localparam int INDEX_W  = 6;
  localparam int COUNT_W  = 7;

  // Number of positions that read_index can address
  localparam int INDEX_SPAN = 2 ** INDEX_W;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_READ   = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  // Per-cell control from the top level
  typedef struct packed {
    logic ins;        // an insert is applied this cycle
    logic valid;      // this cell holds a stored entry
    logic prev_take;  // the left neighbor takes a new value this insert
  } cell_ctl_t;

endpackage

// ----- hdl/sdil_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdil_cell: one position of the sorted list
// Compares the incoming key with its own, and on an insert keeps its entry,
// takes the new entry, or takes its left neighbor's entry (shift right).
// ----------------------------------------------------------------------------
module sdil_cell (
  input  logic               clk,
  input  sdil_pkg::cell_ctl_t ctl,
  input  sdil_pkg::entry_t   new_entry,
  input  sdil_pkg::entry_t   prev_entry,
  output logic               take,
  output sdil_pkg::entry_t   entry
);

  sdil_pkg::entry_t entry_q;

  // Empty cells always take; stored cells take when the new key is strictly larger
  assign take  = !ctl.valid || (new_entry.key > entry_q.key);
  assign entry = entry_q;

  always_ff @(posedge clk) begin
    if (ctl.ins && take) begin
      entry_q <= ctl.prev_take ? prev_entry : new_entry;
    end
  end

endmodule

// ----- hdl/sorted_descending_insert_list_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_descending_insert_list_core: shift-register sorted list
// Holds up to LIST_DEPTH key/handle entries in decreasing key order.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on a rising edge with start high and busy low.
//   opcode OP_INSERT stores entry_key/entry_handle ahead of the first entry
//   with a strictly smaller key (equal keys keep arrival order); a full list
//   rejects it. opcode OP_READ returns the entry at read_index (0 = largest).
//   Each request yields one result, shown for one cycle with done high:
//   accepted, out_key, out_handle and the entry count after the request.
//   An insert, and a read outside the stored range, register the result
//   directly from the request and leave busy low, so such requests may
//   follow every cycle. A read in range holds busy high while its pass
//   runs and strobes its result as busy falls: the cells load a read chain
//   in parallel and it shifts toward position 0 one cell per cycle. The
//   next request is taken as that result leaves.
//   Reset empties the list (count zero) and clears done and busy.
//   The receiver cannot stall; results must be taken when done is high.
// ----------------------------------------------------------------------------
module sorted_descending_insert_list_core #(
  parameter int LIST_DEPTH = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            opcode,
  input  logic [sdil_pkg::KEY_W-1:0]      entry_key,
  input  logic [sdil_pkg::HANDLE_W-1:0]   entry_handle,
  input  logic [sdil_pkg::INDEX_W-1:0]    read_index,
  output logic                            done,
  output logic                            accepted,
  output logic [sdil_pkg::KEY_W-1:0]      out_key,
  output logic [sdil_pkg::HANDLE_W-1:0]   out_handle,
  output logic [sdil_pkg::COUNT_W-1:0]    entry_count
);

  localparam int CW       = $clog2(LIST_DEPTH + 1);
  localparam int CMPW     = (CW > sdil_pkg::INDEX_W) ? CW : sdil_pkg::INDEX_W;
  localparam int RD_CELLS = (LIST_DEPTH < sdil_pkg::INDEX_SPAN) ? LIST_DEPTH
                                                                : sdil_pkg::INDEX_SPAN;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

  state_t                        state;
  logic [CW-1:0]                 fill_count;
  logic [sdil_pkg::INDEX_W-1:0]  cnt;

  sdil_pkg::entry_t    new_entry;
  sdil_pkg::entry_t    cell_entry [LIST_DEPTH];
  sdil_pkg::cell_ctl_t cell_ctl   [LIST_DEPTH];
  logic [LIST_DEPTH-1:0] take;
  sdil_pkg::entry_t    rd         [RD_CELLS];

  logic req;
  logic full;
  logic in_range;
  logic ins_go;
  logic rd_load;
  logic rd_shift;

  assign busy      = (state == ST_READ);
  assign req       = start && !busy;
  assign full      = (fill_count == CW'(LIST_DEPTH));
  assign in_range  = CMPW'(read_index) < CMPW'(fill_count);
  assign ins_go    = req && (opcode == sdil_pkg::OP_INSERT) && !full;
  assign rd_load   = req && (opcode == sdil_pkg::OP_READ) && in_range;
  assign rd_shift  = busy && (cnt != '0);

  assign new_entry.key    = entry_key;
  assign new_entry.handle = entry_handle;

  // Row of cells
  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    sdil_pkg::entry_t prev_entry;

    assign cell_ctl[i].ins   = ins_go;
    assign cell_ctl[i].valid = fill_count > CW'(i);

    if (i == 0) begin : g_head
      assign cell_ctl[i].prev_take = 1'b0;
      assign prev_entry            = '0;
    end else begin : g_body
      assign cell_ctl[i].prev_take = take[i-1];
      assign prev_entry            = cell_entry[i-1];
    end

    sdil_cell u_cell (
      .clk        (clk),
      .ctl        (cell_ctl[i]),
      .new_entry  (new_entry),
      .prev_entry (prev_entry),
      .take       (take[i]),
      .entry      (cell_entry[i])
    );
  end

  // Read chain: load all readable cells, then shift toward position 0
  for (genvar i = 0; i < RD_CELLS; i++) begin : g_rd
    sdil_pkg::entry_t rd_in;

    if (i == RD_CELLS - 1) begin : g_tail
      assign rd_in = '0;
    end else begin : g_link
      assign rd_in = rd[i+1];
    end

    always_ff @(posedge clk) begin
      if (rd_load) begin
        rd[i] <= cell_entry[i];
      end else if (rd_shift) begin
        rd[i] <= rd_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fill_count <= '0;
      cnt        <= '0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            if (opcode == sdil_pkg::OP_INSERT) begin
              done        <= 1'b1;
              accepted    <= !full;
              out_key     <= '0;
              out_handle  <= '0;
              if (!full) begin
                fill_count  <= fill_count + CW'(1);
                entry_count <= sdil_pkg::COUNT_W'(fill_count + CW'(1));
              end else begin
                entry_count <= sdil_pkg::COUNT_W'(fill_count);
              end
            end else if (in_range) begin
              state <= ST_READ;
              cnt   <= read_index;
            end else begin
              done        <= 1'b1;
              accepted    <= 1'b0;
              out_key     <= '0;
              out_handle  <= '0;
              entry_count <= sdil_pkg::COUNT_W'(fill_count);
            end
          end
        end
        ST_READ: begin
          if (cnt == '0) begin
            done        <= 1'b1;
            accepted    <= 1'b1;
            out_key     <= rd[0].key;
            out_handle  <= rd[0].handle;
            entry_count <= sdil_pkg::COUNT_W'(fill_count);
            state       <= ST_IDLE;
          end else begin
            cnt <= cnt - sdil_pkg::INDEX_W'(1);
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CW'(LIST_DEPTH))
    else $error("fill count above list depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    ins_go |=> (fill_count == $past(fill_count) + CW'(1)) && done)
    else $error("stored insert did not grow the list");

  a_head_order: assert property (@(posedge clk) disable iff (rst)
    (fill_count >= CW'(2)) |-> (cell_entry[0].key >= cell_entry[1].key))
    else $error("head entries out of descending order");

  a_read_hold: assert property (@(posedge clk) disable iff (rst)
    rd_shift |=> busy && (fill_count == $past(fill_count)))
    else $error("read pass ended early or list changed during read");

  a_no_strobe_in_pass: assert property (@(posedge clk) disable iff (rst)
    rd_load |=> !done)
    else $error("read result strobed before the pass");
`endif

endmodule
